// ===== src/smk_pkg.sv =====
// shared types, constants and tables for the swerve module kinematics block
package smk_pkg;

  localparam int NumModulesDefault   = 4;
  localparam int CordicStagesDefault = 16;
  localparam int NumRegs             = 8;
  localparam int CfgIdxW             = 3;
  localparam int CfgDataW            = 16;
  localparam int PosSlots            = 4;

  // cordic datapath width: 16 bit components, 8 extra fraction bits, growth room
  localparam int CordW = 28;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         module_res;
    logic [15:0]        wheel_speed;
    logic signed [15:0] steer_angle;
    logic               last;
  } res_t;

  // one module's work as it travels the pipeline
  typedef struct packed {
    logic               valid;
    logic [1:0]         module_res;
    logic               last;
  } tag_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic [31:0]             z;
    logic                    zero;
  } cvec_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10680862;   7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41721;
      15: t = 32'd20860;     16: t = 32'd10430;     17: t = 32'd5215;
      18: t = 32'd2607;      19: t = 32'd1303;      20: t = 32'd651;
      21: t = 32'd325;       22: t = 32'd162;       23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  localparam logic [29:0] GainQ30 = 30'd652032874;

endpackage

// ===== src/swerve_module_kinematics.sv =====
// top level of the four-module swerve drive inverse kinematics pipeline
//
//  port group        dir  meaning
//  start/busy/cmd    in   chassis command, taken when start && !busy
//  result_valid/res  out  one module result per strobe, cannot be held off
//  cfg_we/idx/data   in   module position registers, write only
//
// a command issues its modules one a cycle, so a new command is taken only once
// the previous one has issued all its modules; busy is high while the rest issue.
// results pass the front, cordic and post pipeline registers.
// nothing stalls inside the pipeline since the receiver cannot hold results off.
// rst is synchronous and clears valid bits, sequencing and positions.
module swerve_module_kinematics #(
  parameter int NUM_MODULES   = smk_pkg::NumModulesDefault,
  parameter int CORDIC_STAGES = smk_pkg::CordicStagesDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  smk_pkg::cmd_t                 cmd,
  output logic                          result_valid,
  output smk_pkg::res_t                 result,
  input  logic                          cfg_we,
  input  logic [smk_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [smk_pkg::CfgDataW-1:0]  cfg_data
);

  logic [smk_pkg::NumRegs*16-1:0] regs;

  always_ff @(posedge clk) begin
    if (rst) regs <= '0;
    else if (cfg_we) regs[16*cfg_idx +: 16] <= cfg_data;
  end

  smk_pkg::tag_t      tag_f, tag_c;
  logic signed [15:0] mvx, mvy;
  smk_pkg::cvec_t     vec_c;

  smk_front #(.NUM_MODULES(NUM_MODULES)) u_front (
    .clk, .rst, .start, .cmd, .pos(regs), .busy,
    .tag_out(tag_f), .mvx, .mvy
  );

  smk_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst, .tag_in(tag_f), .mvx, .mvy, .tag_out(tag_c), .vec_out(vec_c)
  );

  smk_post u_post (
    .clk, .rst, .tag_in(tag_c), .vec_in(vec_c), .result_valid, .result
  );

`ifndef SYNTH
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && NUM_MODULES > 1) |=> busy)
    else $error("busy not raised after command");
  a_busy_needs_start: assert property (@(posedge clk) disable iff (rst)
    (!start && !busy) |=> !busy)
    else $error("busy raised without a command");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last && NUM_MODULES == 4) |-> result.module_res == 2'd3)
    else $error("last flag on wrong module");
`endif

endmodule

// ===== src/smk_front.sv =====
// module sequencing and module velocity stages (multiply, sum, round and saturate)
module smk_front #(
  parameter int NUM_MODULES = smk_pkg::NumModulesDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  smk_pkg::cmd_t                       cmd,
  input  logic [smk_pkg::PosSlots*32-1:0]     pos,
  output logic                                busy,
  output smk_pkg::tag_t                       tag_out,
  output logic signed [15:0]                  mvx,
  output logic signed [15:0]                  mvy
);

  localparam int CntW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

  logic              active;
  logic [CntW-1:0]   cnt;
  smk_pkg::cmd_t     cur;
  logic              take;
  logic              issue;
  logic [CntW-1:0]   idx;
  smk_pkg::cmd_t     icmd;
  logic [1:0]        slot;
  logic signed [15:0] px;
  logic signed [15:0] py;

  // a command is issued straight away as module 0, the rest follow one a cycle
  assign busy  = active;
  assign take  = start && !active;
  assign issue = take || active;
  assign idx   = active ? cnt : '0;
  assign icmd  = active ? cur : cmd;
  assign slot  = 2'(idx);
  assign px    = pos[32*slot +: 16];
  assign py    = pos[32*slot + 16 +: 16];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (issue) begin
      if (idx == CntW'(NUM_MODULES - 1)) begin
        active <= 1'b0;
        cnt    <= '0;
      end else begin
        active <= 1'b1;
        cnt    <= idx + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= cmd;
  end

  // stage 1: products
  smk_pkg::tag_t      t1;
  logic signed [31:0] wy1, wx1;
  logic signed [15:0] vx1, vy1;
  always_ff @(posedge clk) begin
    if (rst) t1.valid <= 1'b0;
    else     t1.valid <= issue;
    t1.module_res <= slot;
    t1.last       <= (idx == CntW'(NUM_MODULES - 1));
    wy1 <= icmd.yaw_rate * py;
    wx1 <= icmd.yaw_rate * px;
    vx1 <= icmd.vel_x;
    vy1 <= icmd.vel_y;
  end

  // stage 2: sums with rounding offset
  smk_pkg::tag_t      t2;
  logic signed [33:0] sx2, sy2;
  always_ff @(posedge clk) begin
    if (rst) t2.valid <= 1'b0;
    else     t2.valid <= t1.valid;
    t2.module_res <= t1.module_res;
    t2.last       <= t1.last;
    sx2 <= {{6{vx1[15]}}, vx1, 12'd0} - 34'(wy1) + 34'sd2048;
    sy2 <= {{6{vy1[15]}}, vy1, 12'd0} + 34'(wx1) + 34'sd2048;
  end

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767)       return 16'sh7fff;
    else if (v < -22'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  // stage 3: shift and saturate
  always_ff @(posedge clk) begin
    if (rst) tag_out.valid <= 1'b0;
    else     tag_out.valid <= t2.valid;
    tag_out.module_res <= t2.module_res;
    tag_out.last       <= t2.last;
    mvx <= sat16(sx2[33:12]);
    mvy <= sat16(sy2[33:12]);
  end

endmodule

// ===== src/smk_cordic.sv =====
// pipelined vectoring cordic, one rotation stage per register
module smk_cordic #(
  parameter int CORDIC_STAGES = smk_pkg::CordicStagesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  smk_pkg::tag_t      tag_in,
  input  logic signed [15:0] mvx,
  input  logic signed [15:0] mvy,
  output smk_pkg::tag_t      tag_out,
  output smk_pkg::cvec_t     vec_out
);

  localparam int W = smk_pkg::CordW;

  smk_pkg::tag_t  tg [CORDIC_STAGES+1];
  smk_pkg::cvec_t cv [CORDIC_STAGES+1];

  // pre-rotation by pi for the left half plane
  always_ff @(posedge clk) begin
    logic signed [W-1:0] x0, y0;
    x0 = W'(mvx) <<< 8;
    y0 = W'(mvy) <<< 8;
    if (rst) tg[0].valid <= 1'b0;
    else     tg[0].valid <= tag_in.valid;
    tg[0].module_res <= tag_in.module_res;
    tg[0].last       <= tag_in.last;
    cv[0].zero <= (mvx == 16'sd0) && (mvy == 16'sd0);
    if (mvx < 0) begin
      cv[0].x <= -x0;
      cv[0].y <= -y0;
      cv[0].z <= 32'h8000_0000;
    end else begin
      cv[0].x <= x0;
      cv[0].y <= y0;
      cv[0].z <= 32'd0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [W-1:0] dx, dy;
    assign dx = cv[i].y >>> i;
    assign dy = cv[i].x >>> i;
    always_ff @(posedge clk) begin
      if (rst) tg[i+1].valid <= 1'b0;
      else     tg[i+1].valid <= tg[i].valid;
      tg[i+1].module_res <= tg[i].module_res;
      tg[i+1].last       <= tg[i].last;
      cv[i+1].zero       <= cv[i].zero;
      if (!cv[i].y[W-1]) begin
        cv[i+1].x <= cv[i].x + dx;
        cv[i+1].y <= cv[i].y - dy;
        cv[i+1].z <= cv[i].z + smk_pkg::atan_entry(i);
      end else begin
        cv[i+1].x <= cv[i].x - dx;
        cv[i+1].y <= cv[i].y + dy;
        cv[i+1].z <= cv[i].z - smk_pkg::atan_entry(i);
      end
    end
  end

  assign tag_out = tg[CORDIC_STAGES];
  assign vec_out = cv[CORDIC_STAGES];

endmodule

// ===== src/smk_post.sv =====
// gain compensation, angle rounding and result register
module smk_post (
  input  logic           clk,
  input  logic           rst,
  input  smk_pkg::tag_t  tag_in,
  input  smk_pkg::cvec_t vec_in,
  output logic           result_valid,
  output smk_pkg::res_t  result
);

  localparam int W = smk_pkg::CordW;

  smk_pkg::tag_t  t1;
  logic [W+29:0]  prod;
  logic [15:0]    ang1;
  logic           zero1;
  logic [W-2:0]   xpos;

  assign xpos = vec_in.x[W-1] ? '0 : vec_in.x[W-2:0];

  always_ff @(posedge clk) begin
    logic [31:0] zr;
    zr = vec_in.z + 32'h0000_8000;
    if (rst) t1.valid <= 1'b0;
    else     t1.valid <= tag_in.valid;
    t1.module_res <= tag_in.module_res;
    t1.last       <= tag_in.last;
    prod  <= (W+30)'(xpos) * (W+30)'(smk_pkg::GainQ30);
    ang1  <= zr[31:16];
    zero1 <= vec_in.zero;
  end

  logic [W+29:0] mr;
  assign mr = (prod + ((W+30)'(1) << 37)) >> 38;

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= t1.valid;
    result.module_res <= t1.module_res;
    result.last       <= t1.last;
    if (zero1) begin
      result.wheel_speed <= 16'd0;
      result.steer_angle <= 16'sd0;
    end else begin
      result.wheel_speed <= (mr > (W+30)'(65535)) ? 16'hffff : mr[15:0];
      result.steer_angle <= ang1;
    end
  end

endmodule
